FILE: src/tsfm_pkg.sv
// Package for the touch sample filter and mapper.
// Holds field widths, register codes, reset values, state types and the axis status.
// Used by tsfm_axis and touch_sample_filter_mapper_top; depends on nothing else.
package tsfm_pkg;

   localparam int RAW_W   = 12;   // raw conversion and register width
   localparam int SUM_W   = 14;   // width of the sum of three samples
   localparam int X_POS_W = 9;
   localparam int Y_POS_W = 8;
   localparam int CSR_IDX_W = 3;

   localparam int SCREEN_WIDTH_DEF  = 320;
   localparam int SCREEN_HEIGHT_DEF = 240;

   localparam int AXIS_LOW_LIMIT  = 50;
   localparam int AXIS_HIGH_LIMIT = 4090;
   localparam int AVG_DIVISOR     = 3;

   localparam logic [RAW_W-1:0] PRESSURE_MIN_RST = RAW_W'(80);
   localparam logic [RAW_W-1:0] X_RAW_MIN_RST    = RAW_W'(240);
   localparam logic [RAW_W-1:0] X_RAW_MAX_RST    = RAW_W'(3850);
   localparam logic [RAW_W-1:0] Y_RAW_MIN_RST    = RAW_W'(220);
   localparam logic [RAW_W-1:0] Y_RAW_MAX_RST    = RAW_W'(3820);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PRESSURE_MIN = 3'd0,
      REG_X_RAW_MIN    = 3'd1,
      REG_X_RAW_MAX    = 3'd2,
      REG_Y_RAW_MIN    = 3'd3,
      REG_Y_RAW_MAX    = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      AX_IDLE,
      AX_AVG,
      AX_CHK,
      AX_MUL,
      AX_DIV,
      AX_FIN,
      AX_DONE
   } axis_state_type;

   typedef struct packed {
      logic done;
      logic ok;
   } axis_status_type;

endpackage

FILE: src/tsfm_axis.sv
// One axis of the touch mapper: bit-serial average, multiply and divide.
// A single restoring divider serves both the divide by three and the calibration divide.
// Depends on tsfm_pkg.
module tsfm_axis #(
   parameter int SIZE = tsfm_pkg::SCREEN_WIDTH_DEF,
   parameter int FW   = tsfm_pkg::X_POS_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tsfm_pkg::RAW_W-1:0]   sample_a,
   input  logic [tsfm_pkg::RAW_W-1:0]   sample_b,
   input  logic [tsfm_pkg::RAW_W-1:0]   sample_c,
   input  logic [tsfm_pkg::RAW_W-1:0]   raw_min,
   input  logic [tsfm_pkg::RAW_W-1:0]   raw_max,
   output tsfm_pkg::axis_status_type    status,
   output logic [FW-1:0]                pos
);
   import tsfm_pkg::*;

   localparam int TOP_W = $clog2(SIZE);
   localparam logic [TOP_W-1:0] TOP = TOP_W'(SIZE - 1);
   localparam int PW    = RAW_W + TOP_W;
   localparam int DW    = (PW > SUM_W) ? PW : SUM_W;
   localparam int CNT_W = $clog2(DW);
   localparam int MW    = (TOP_W > FW) ? TOP_W : FW;

   axis_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RAW_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [RAW_W-1:0] div_ff, div_in;
   logic [RAW_W-1:0] mcand_ff, mcand_in;
   logic [RAW_W-1:0] mhi_ff, mhi_in;
   logic [TOP_W-1:0] mlo_ff, mlo_in;
   logic [TOP_W-1:0] pos_ff, pos_in;
   logic             ok_ff, ok_in;

   logic [SUM_W-1:0] sum;
   logic [RAW_W:0]   rs;
   logic             ge;
   logic [RAW_W:0]   madd;
   logic [TOP_W:0]   mlo_sh;
   logic [PW-1:0]    prod;
   logic [SUM_W-1:0] avg;
   logic [PW-1:0]    quot;
   logic [MW-1:0]    pos_ext;

   always_comb begin
      sum  = SUM_W'(sample_a) + SUM_W'(sample_b) + SUM_W'(sample_c);
      // One restoring step: bring in the next dividend bit, subtract when it fits.
      rs   = {rem_ff, quo_ff[DW-1]};
      ge   = rs >= {1'b0, div_ff};
      // One shift-add step of the multiplier, least significant bit of TOP first.
      madd = {1'b0, mhi_ff} + (mlo_ff[0] ? {1'b0, mcand_ff} : {(RAW_W + 1){1'b0}});
      mlo_sh = {madd[0], mlo_ff};
      prod   = {madd[RAW_W:1], mlo_sh[TOP_W:1]};
      avg    = quo_ff[SUM_W-1:0];
      quot   = quo_ff[PW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      mcand_in = mcand_ff;
      mhi_in   = mhi_ff;
      mlo_in   = mlo_ff;
      pos_in   = pos_ff;
      ok_in    = ok_ff;
      unique case (state_ff)
         AX_IDLE, AX_DONE: begin
            if (start) begin
               quo_in   = DW'(sum) << (DW - SUM_W);
               rem_in   = '0;
               div_in   = RAW_W'(AVG_DIVISOR);
               cnt_in   = '0;
               state_in = AX_AVG;
            end
         end
         AX_AVG, AX_DIV: begin
            rem_in = ge ? RAW_W'(rs - {1'b0, div_ff}) : rs[RAW_W-1:0];
            quo_in = {quo_ff[DW-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (state_ff == AX_AVG && cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = AX_CHK;
            end else if (state_ff == AX_DIV && cnt_ff == CNT_W'(PW - 1)) begin
               state_in = AX_FIN;
            end
         end
         AX_CHK: begin
            ok_in = (avg >= SUM_W'(AXIS_LOW_LIMIT)) && (avg <= SUM_W'(AXIS_HIGH_LIMIT)) &&
                    (raw_max > raw_min);
            // At or below the minimum the inverted map lands on or past the far edge.
            if (!ok_in || avg[RAW_W-1:0] <= raw_min) begin
               pos_in   = TOP;
               state_in = AX_DONE;
            end else begin
               mcand_in = avg[RAW_W-1:0] - raw_min;
               mhi_in   = '0;
               mlo_in   = TOP;
               cnt_in   = '0;
               state_in = AX_MUL;
            end
         end
         AX_MUL: begin
            mhi_in = madd[RAW_W:1];
            mlo_in = mlo_sh[TOP_W:1];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(TOP_W - 1)) begin
               quo_in   = DW'(prod) << (DW - PW);
               rem_in   = '0;
               div_in   = raw_max - raw_min;
               cnt_in   = '0;
               state_in = AX_DIV;
            end
         end
         AX_FIN: begin
            pos_in   = (quot >= PW'(TOP)) ? '0 : TOP - quot[TOP_W-1:0];
            state_in = AX_DONE;
         end
         default: begin
            state_in = AX_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AX_IDLE;
         cnt_ff   <= '0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ok_ff    <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
      mcand_ff <= mcand_in;
      mhi_ff   <= mhi_in;
      mlo_ff   <= mlo_in;
      pos_ff   <= pos_in;
   end

   assign pos_ext     = MW'(pos_ff);
   assign pos         = pos_ext[FW-1:0];
   assign status.done = (state_ff == AX_DONE);
   assign status.ok   = ok_ff;

endmodule

FILE: src/touch_sample_filter_mapper_top.sv
// Touch sample filter and mapper: top level with registers, held position and output stage.
// A touch item runs the bit-serial average, multiply and divide in both axis units, and EMIT
// then loads the output register; an axis failing its checks or at or below its minimum skips
// the multiply and divide; other items go straight to EMIT. Throughput: one item at a time, the
// next accepted in the cycle after a result is loaded, even while it waits. Synchronous reset
// restores the register defaults and clears the held position.
module touch_sample_filter_mapper_top #(
   parameter int SCREEN_WIDTH  = tsfm_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tsfm_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_touch_request,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_pressure,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_x_sample_a,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_x_sample_b,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_x_sample_c,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_y_sample_a,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_y_sample_b,
   input  logic [tsfm_pkg::RAW_W-1:0]       req_y_sample_c,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [tsfm_pkg::X_POS_W-1:0]     rsp_x_pos,
   output logic [tsfm_pkg::Y_POS_W-1:0]     rsp_y_pos,
   output logic                             rsp_pressed,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsfm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tsfm_pkg::RAW_W-1:0]       csr_data
);
   import tsfm_pkg::*;

   top_state_type state_ff, state_in;
   logic press_ff, press_in;
   logic [X_POS_W-1:0] held_x_ff, held_x_in;
   logic [Y_POS_W-1:0] held_y_ff, held_y_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [X_POS_W-1:0] rsp_x_pos_ff, rsp_x_pos_in;
   logic [Y_POS_W-1:0] rsp_y_pos_ff, rsp_y_pos_in;
   logic rsp_pressed_ff, rsp_pressed_in;
   logic [RAW_W-1:0] pressure_min_ff, pressure_min_in;
   logic [RAW_W-1:0] x_raw_min_ff, x_raw_min_in;
   logic [RAW_W-1:0] x_raw_max_ff, x_raw_max_in;
   logic [RAW_W-1:0] y_raw_min_ff, y_raw_min_in;
   logic [RAW_W-1:0] y_raw_max_ff, y_raw_max_in;

   logic            accept;
   logic            start;
   axis_status_type x_status, y_status;
   logic [X_POS_W-1:0] x_pos;
   logic [Y_POS_W-1:0] y_pos;

   tsfm_axis #(
      .SIZE (SCREEN_WIDTH),
      .FW   (X_POS_W)
   ) u_axis_x (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .sample_a (req_x_sample_a),
      .sample_b (req_x_sample_b),
      .sample_c (req_x_sample_c),
      .raw_min  (x_raw_min_ff),
      .raw_max  (x_raw_max_ff),
      .status   (x_status),
      .pos      (x_pos)
   );

   tsfm_axis #(
      .SIZE (SCREEN_HEIGHT),
      .FW   (Y_POS_W)
   ) u_axis_y (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .sample_a (req_y_sample_a),
      .sample_b (req_y_sample_b),
      .sample_c (req_y_sample_c),
      .raw_min  (y_raw_min_ff),
      .raw_max  (y_raw_max_ff),
      .status   (y_status),
      .pos      (y_pos)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign start     = accept && req_touch_request && (req_pressure >= pressure_min_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      pressure_min_in = pressure_min_ff;
      x_raw_min_in    = x_raw_min_ff;
      x_raw_max_in    = x_raw_max_ff;
      y_raw_min_in    = y_raw_min_ff;
      y_raw_max_in    = y_raw_max_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PRESSURE_MIN: pressure_min_in = csr_data;
            REG_X_RAW_MIN:    x_raw_min_in    = csr_data;
            REG_X_RAW_MAX:    x_raw_max_in    = csr_data;
            REG_Y_RAW_MIN:    y_raw_min_in    = csr_data;
            REG_Y_RAW_MAX:    y_raw_max_in    = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      press_in       = press_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_x_pos_in   = rsp_x_pos_ff;
      rsp_y_pos_in   = rsp_y_pos_ff;
      rsp_pressed_in = rsp_pressed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
            end else if (accept) begin
               press_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_RUN: begin
            if (x_status.done && y_status.done) begin
               press_in = x_status.ok && y_status.ok;
               if (x_status.ok && y_status.ok) begin
                  held_x_in = x_pos;
                  held_y_in = y_pos;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // The output register is free once any waiting item is taken this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_x_pos_in   = held_x_ff;
               rsp_y_pos_in   = held_y_ff;
               rsp_pressed_in = press_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         press_ff        <= 1'b0;
         held_x_ff       <= '0;
         held_y_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         pressure_min_ff <= PRESSURE_MIN_RST;
         x_raw_min_ff    <= X_RAW_MIN_RST;
         x_raw_max_ff    <= X_RAW_MAX_RST;
         y_raw_min_ff    <= Y_RAW_MIN_RST;
         y_raw_max_ff    <= Y_RAW_MAX_RST;
      end else begin
         state_ff        <= state_in;
         press_ff        <= press_in;
         held_x_ff       <= held_x_in;
         held_y_ff       <= held_y_in;
         rsp_valid_ff    <= rsp_valid_in;
         pressure_min_ff <= pressure_min_in;
         x_raw_min_ff    <= x_raw_min_in;
         x_raw_max_ff    <= x_raw_max_in;
         y_raw_min_ff    <= y_raw_min_in;
         y_raw_max_ff    <= y_raw_max_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_pos_ff   <= rsp_x_pos_in;
      rsp_y_pos_ff   <= rsp_y_pos_in;
      rsp_pressed_ff <= rsp_pressed_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_x_pos   = rsp_x_pos_ff;
   assign rsp_y_pos   = rsp_y_pos_ff;
   assign rsp_pressed = rsp_pressed_ff;

endmodule
